/* hw/rtl/gms_pkg.sv */
// Shared constants and types for the Gaussian Metropolis sampler.
// No dependencies; compiled first.
`default_nettype none

package gms_pkg;

  localparam int unsigned RANDOM_BITS_DEFAULT = 16;
  localparam int unsigned FRAC_BITS           = 16;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned SPREAD_W   = 31;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SPREAD_W-1:0] SPREAD_RESET = SPREAD_W'(1) << FRAC_BITS;

  // exp(-1) in unsigned Q0.32 and 1.0 in unsigned Q1.32
  localparam logic [31:0] EXP_M1_Q32 = 32'd1580030169;
  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

  localparam int unsigned TAYLOR_TERMS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_MEAN   = CFG_IDX_W'(0),
    REG_TARGET_SPREAD = CFG_IDX_W'(1)
  } cfg_reg_e;

endpackage

`default_nettype wire

/* hw/rtl/gms_if.sv */
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on gms_pkg.
`default_nettype none

interface gms_in_if #(
  parameter int unsigned RANDOM_BITS = gms_pkg::RANDOM_BITS_DEFAULT
) ();
  logic                   valid;
  logic                   ready;
  logic                   restart;
  logic [RANDOM_BITS-1:0] step_random;
  logic [RANDOM_BITS-1:0] accept_random;

  modport source (output valid, restart, step_random, accept_random, input ready);
  modport sink   (input valid, restart, step_random, accept_random, output ready);
endinterface

interface gms_out_if ();
  import gms_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                accepted;

  modport source (output valid, sample, accepted, input ready);
  modport sink   (input valid, sample, accepted, output ready);
endinterface

interface gms_cfg_if ();
  import gms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/gaussian_metropolis_sampler.sv */
// Random-walk Metropolis sampler for a Gaussian target, signed Q16.16 samples.
// Depends on gms_pkg and the channel interfaces in gms_if.
//
// One item is worked on at a time and in_i.ready is high only between items. A restart
// transaction goes straight to S_DONE. A proposal that does not lower the target density
// goes straight from the density check to the accept test. If the integer part k of the
// scaled square difference is 32 or more, the ratio is zero straight after the division.
// Any other proposal (k 0..31) goes through restoring division for the exponent, 16 Taylor
// terms, each one multiply and a byte-wise division by the term number, and k multiplies
// by exp(-1). All products go through one shared 33x32 multiplier. The result sits in an
// output register; while the sink stalls, the sampler waits in S_DONE and takes no new
// item until that register is free. Config writes are always taken.
`default_nettype none

module gaussian_metropolis_sampler #(
  parameter int unsigned RANDOM_BITS = gms_pkg::RANDOM_BITS_DEFAULT
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  gms_in_if.sink     in_i,
  gms_out_if.source  out_o,
  gms_cfg_if.sink    cfg_i
);
  import gms_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PROP  = 4'd1;
  localparam logic [3:0] S_CAND  = 4'd2;
  localparam logic [3:0] S_SQA   = 4'd3;
  localparam logic [3:0] S_SQB   = 4'd4;
  localparam logic [3:0] S_DEN   = 4'd5;
  localparam logic [3:0] S_DLOAD = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_TMUL  = 4'd8;
  localparam logic [3:0] S_TDIV  = 4'd9;
  localparam logic [3:0] S_EXPK  = 4'd10;
  localparam logic [3:0] S_EXPM  = 4'd11;
  localparam logic [3:0] S_TEST  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  localparam int unsigned INT_STEPS = 6;
  localparam int unsigned DIV_STEPS = INT_STEPS + 32;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [RANDOM_BITS-1:0] RND_HALF = {1'b1, {(RANDOM_BITS-1){1'b0}}};

  logic [3:0]             state_q, state_d;
  logic [SAMPLE_W-1:0]    mean_q, cur_q;
  logic [SPREAD_W-1:0]    spread_q;
  logic [RANDOM_BITS-1:0] r1_q, r2_q;
  logic [63:0]            prod_q, asq_q, rem_q;
  logic [31:0]            aa_q, bb_q, cand_q;
  logic [68:0]            dvs_q;
  logic [DCNT_W-1:0]      dcnt_q;
  logic [37:0]            kf_q;
  logic [32:0]            term_q, r_q;
  logic signed [34:0]     sum_q;
  logic [4:0]             n_q, kcnt_q;
  logic [1:0]             tdc_q;
  logic [4:0]             tdr_q;
  logic [31:0]            tdq_q, tdd_q;
  logic [SAMPLE_W-1:0]    res_sample_q, out_sample_q;
  logic                   res_acc_q, out_acc_q, out_valid_q;

  logic                   in_acc, cfg_acc, out_free;
  logic [SPREAD_W-1:0]    sig_eff;
  logic [RANDOM_BITS-1:0] d_mag;
  logic                   d_neg, low_nz;
  logic [32:0]            dx_mag, dx, cand_sum;
  logic [31:0]            cand_sat, aa_c, bb_c;
  logic [32:0]            diff_a, diff_b;
  logic [32:0]            mul_a;
  logic [31:0]            mul_b;
  logic [64:0]            mul_p;
  logic                   div_frac, div_ge;
  logic [63:0]            div_lhs;
  logic [68:0]            div_diff;
  logic [37:0]            kf_next;
  logic [31:0]            td_dvd;
  logic [4:0]             td_rin;
  logic [12:0]            td_res;
  logic [31:0]            td_quo;
  logic [31:0]            thr;
  logic                   take;

  // Eight steps of restoring division of a byte by a divisor of at most 16.
  function automatic logic [12:0] div_byte(logic [4:0] rin, logic [7:0] bits,
                                           logic [4:0] dvs);
    logic [4:0] r;
    logic [5:0] t;
    logic [7:0] q;
    r = rin;
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, dvs}) begin
        r    = 5'(t - {1'b0, dvs});
        q[i] = 1'b1;
      end else begin
        r = t[4:0];
      end
    end
    return {r, q};
  endfunction

  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready     = (state_q == S_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.sample   = out_sample_q;
  assign out_o.accepted = out_acc_q;

  assign sig_eff = (spread_q == '0) ? SPREAD_W'(1) : spread_q;

  // Proposal offset: floor((r1 - half) * sigma / 2^RANDOM_BITS)
  assign d_neg  = !r1_q[RANDOM_BITS-1];
  assign d_mag  = d_neg ? (RND_HALF - r1_q) : (r1_q - RND_HALF);
  assign low_nz = |(prod_q & ((64'd1 << RANDOM_BITS) - 64'd1));
  assign dx_mag = 33'(prod_q >> RANDOM_BITS) + 33'(d_neg && low_nz);
  assign dx     = d_neg ? (33'd0 - dx_mag) : dx_mag;

  assign cand_sum = {cur_q[31], cur_q} + dx;
  always_comb begin
    if (cand_sum[32] != cand_sum[31]) begin
      cand_sat = cand_sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      cand_sat = cand_sum[31:0];
    end
  end

  assign diff_a = {cur_q[31], cur_q} - {mean_q[31], mean_q};
  assign diff_b = {cand_q[31], cand_q} - {mean_q[31], mean_q};
  assign aa_c   = diff_a[32] ? 32'(33'd0 - diff_a) : diff_a[31:0];
  assign bb_c   = diff_b[32] ? 32'(33'd0 - diff_b) : diff_b[31:0];

  // Shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PROP: begin
        mul_a = 33'(d_mag);
        mul_b = 32'(sig_eff);
      end
      S_CAND: begin
        mul_a = 33'(aa_q);
        mul_b = aa_q;
      end
      S_SQB: begin
        mul_a = 33'(bb_q);
        mul_b = bb_q;
      end
      S_DEN: begin
        mul_a = 33'(sig_eff);
        mul_b = 32'(sig_eff);
      end
      S_TMUL: begin
        mul_a = term_q;
        mul_b = kf_q[31:0];
      end
      S_EXPM: begin
        mul_a = r_q;
        mul_b = EXP_M1_Q32;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = 65'(mul_a) * 65'(mul_b);

  // Exponent divider: integer bits against a right-shifting divisor, then fraction bits
  assign div_frac = (dcnt_q >= DCNT_W'(INT_STEPS));
  assign div_lhs  = div_frac ? {rem_q[62:0], 1'b0} : rem_q;
  assign div_diff = {5'd0, div_lhs} - dvs_q;
  assign div_ge   = ({5'd0, div_lhs} >= dvs_q);
  assign kf_next  = {kf_q[36:0], div_ge};

  // Taylor term divider, one byte per cycle
  assign td_dvd = (tdc_q == 2'd0) ? prod_q[63:32] : tdd_q;
  assign td_rin = (tdc_q == 2'd0) ? 5'd0 : tdr_q;
  assign td_res = div_byte(td_rin, td_dvd[31:24], n_q);
  assign td_quo = {tdq_q[23:0], td_res[7:0]};

  assign thr  = 32'(r2_q) << (32 - RANDOM_BITS);
  assign take = ({1'b0, thr} <= r_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = in_i.restart ? S_DONE : S_PROP;
        end
      end
      S_PROP:  state_d = S_CAND;
      S_CAND:  state_d = S_SQA;
      S_SQA:   state_d = S_SQB;
      S_SQB:   state_d = S_DEN;
      S_DEN:   state_d = (prod_q <= asq_q) ? S_TEST : S_DLOAD;
      S_DLOAD: state_d = S_DIV;
      S_DIV: begin
        if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          state_d = kf_next[37] ? S_TEST : S_TMUL;
        end
      end
      S_TMUL:  state_d = S_TDIV;
      S_TDIV: begin
        if (tdc_q == 2'd3) begin
          state_d = (n_q == 5'(TAYLOR_TERMS)) ? S_EXPK : S_TMUL;
        end
      end
      S_EXPK:  state_d = (kf_q[36:32] == 5'd0) ? S_TEST : S_EXPM;
      S_EXPM:  state_d = (kcnt_q == 5'd1) ? S_TEST : S_EXPM;
      S_TEST:  state_d = S_DONE;
      S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mean_q      <= '0;
      spread_q    <= SPREAD_RESET;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      tdc_q       <= '0;
      n_q         <= 5'd1;
      kcnt_q      <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_acc) begin
        case (cfg_i.index)
          REG_TARGET_MEAN:   mean_q   <= cfg_i.data;
          REG_TARGET_SPREAD: spread_q <= cfg_i.data[SPREAD_W-1:0];
          default: ;
        endcase
      end

      if (state_q == S_DONE && out_free) begin
        cur_q       <= res_sample_q;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_DLOAD: dcnt_q <= '0;
        S_DIV: begin
          dcnt_q <= dcnt_q + DCNT_W'(1);
          n_q    <= 5'd1;
          tdc_q  <= '0;
        end
        S_TDIV: begin
          tdc_q <= tdc_q + 2'd1;
          if (tdc_q == 2'd3) begin
            n_q <= n_q + 5'd1;
          end
        end
        S_EXPK:  kcnt_q <= kf_q[36:32];
        S_EXPM:  kcnt_q <= kcnt_q - 5'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[63:0];

    if (state_q == S_DONE && out_free) begin
      out_sample_q <= res_sample_q;
      out_acc_q    <= res_acc_q;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          r1_q         <= in_i.step_random;
          r2_q         <= in_i.accept_random;
          res_sample_q <= mean_q;
          res_acc_q    <= 1'b1;
        end
      end
      S_PROP: aa_q <= aa_c;
      S_CAND: cand_q <= cand_sat;
      S_SQA: begin
        asq_q <= prod_q;
        bb_q  <= bb_c;
      end
      S_DEN: begin
        if (prod_q <= asq_q) begin
          r_q <= ONE_Q32;
        end else begin
          rem_q <= prod_q - asq_q;
        end
      end
      S_DLOAD: begin
        dvs_q <= {prod_q[62:0], 6'd0};
        kf_q  <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? div_diff[63:0] : div_lhs;
        kf_q  <= kf_next;
        if (dcnt_q < DCNT_W'(INT_STEPS - 1)) begin
          dvs_q <= dvs_q >> 1;
        end
        term_q <= ONE_Q32;
        sum_q  <= $signed({2'b00, ONE_Q32});
        if (dcnt_q == DCNT_W'(DIV_STEPS - 1) && kf_next[37]) begin
          r_q <= '0;
        end
      end
      S_TDIV: begin
        tdd_q <= {td_dvd[23:0], 8'd0};
        tdr_q <= td_res[12:8];
        tdq_q <= td_quo;
        if (tdc_q == 2'd3) begin
          term_q <= {1'b0, td_quo};
          if (n_q[0]) begin
            sum_q <= sum_q - $signed({3'b000, td_quo});
          end else begin
            sum_q <= sum_q + $signed({3'b000, td_quo});
          end
        end
      end
      S_EXPK: r_q <= sum_q[34] ? 33'd0 : sum_q[32:0];
      S_EXPM: r_q <= mul_p[64:32];
      S_TEST: begin
        res_sample_q <= take ? cand_q : cur_q;
        res_acc_q    <= take;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/gms_checker.sv */
// Port-level checks for gaussian_metropolis_sampler, bound to the top level.
// Depends on gms_pkg.
`default_nettype none

module gms_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_ready_i,
  input wire                          in_restart_i,
  input wire                          out_valid_i,
  input wire                          out_ready_i,
  input wire [gms_pkg::SAMPLE_W-1:0]  out_sample_i,
  input wire                          out_accepted_i
);
  import gms_pkg::*;

  logic                in_acc, out_acc;
  logic [SAMPLE_W-1:0] last_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // last delivered sample, i.e. the chain state a rejected move must repeat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (out_acc) begin
      last_q <= out_sample_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i)
                                    && $stable(out_accepted_i))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("ready after accepting a transaction");

  a_restart_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_restart_i ##1 (!out_valid_i || out_ready_i) |=> out_valid_i && out_accepted_i)
    else $error("restart result missing or not flagged accepted");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_accepted_i |-> out_sample_i == last_q)
    else $error("rejected move changed the sample");

endmodule

bind gaussian_metropolis_sampler gms_checker u_gms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_restart_i   (in_i.restart),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_sample_i   (out_o.sample),
  .out_accepted_i (out_o.accepted)
);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking bench for the Gaussian Metropolis sampler: random and directed chains,
// checked against a fixed-point model of the sampler kept in a scoreboard class.
// Depends on gms_pkg, the channel interfaces in gms_if and gaussian_metropolis_sampler.
`timescale 1ns / 100ps

module testbench;
  import gms_pkg::*;

  localparam int unsigned RB          = RANDOM_BITS_DEFAULT;
  localparam longint      SAMPLE_MAX  = 64'sd2147483647;
  localparam longint      SAMPLE_MIN  = -64'sd2147483648;
  localparam longint      HALF_STEP   = longint'(1) << (RB - 1);
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                accepted;
  } sample_item_t;

  class chain_checker;
    logic signed [SAMPLE_W-1:0] mean_q;
    logic [SPREAD_W-1:0]        spread_q;
    logic signed [SAMPLE_W-1:0] chain_q;
    sample_item_t               expected_samples[$];
    int unsigned errors, n_items, n_restart, n_taken, n_kept;
    int unsigned n_flat, n_graded, n_cutoff, n_clipped;

    function new();
      mean_q   = '0;
      spread_q = SPREAD_RESET;
      chain_q  = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TARGET_MEAN:   mean_q = data;
        REG_TARGET_SPREAD: spread_q = data[SPREAD_W-1:0];
        default: ;
      endcase
    endfunction

    // exp(-(k + f/2^32)) in Q0.32
    function bit [63:0] exp_neg_q32(bit [63:0] k, bit [63:0] f);
      longint    total;
      bit [63:0] term;
      bit [63:0] r;
      if (k >= 32) return 64'd0;
      total = longint'(ONE_Q32);
      term  = 64'(ONE_Q32);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = ((term * f) >> 32) / n;
        if (n % 2) total -= longint'(term);
        else total += longint'(term);
      end
      if (total < 0) total = 0;
      r = total;
      repeat (k) r = (r * EXP_M1_Q32) >> 32;
      return r;
    endfunction

    function void predict_step(bit restart, logic [RB-1:0] step_r, logic [RB-1:0] accept_r);
      longint       sig, offset, cand, dist_cur, dist_cand;
      bit [63:0]    sq_cur, sq_cand, excess, den, k, rem, f, ratio, thr;
      sample_item_t item;
      n_items++;
      sig = longint'(spread_q);
      if (sig == 0) sig = 1;
      item.accepted = 1'b1;
      if (restart) begin
        chain_q = mean_q;
        n_restart++;
      end else begin
        offset = longint'(step_r);
        offset = ((offset - HALF_STEP) * sig) >>> RB;
        cand   = chain_q + offset;
        if (cand > SAMPLE_MAX) begin
          cand = SAMPLE_MAX;
          n_clipped++;
        end else if (cand < SAMPLE_MIN) begin
          cand = SAMPLE_MIN;
          n_clipped++;
        end
        dist_cur  = chain_q - mean_q;
        dist_cand = cand - mean_q;
        if (dist_cur < 0) dist_cur = -dist_cur;
        if (dist_cand < 0) dist_cand = -dist_cand;
        sq_cur  = dist_cur;
        sq_cur  = sq_cur * sq_cur;
        sq_cand = dist_cand;
        sq_cand = sq_cand * sq_cand;
        if (sq_cand <= sq_cur) begin
          ratio = 64'(ONE_Q32);
          n_flat++;
        end else begin
          excess = sq_cand - sq_cur;
          den    = sig;
          den    = (den * den) << 1;
          k      = excess / den;
          rem    = excess % den;
          f      = '0;
          repeat (32) begin
            rem = rem << 1;
            f   = f << 1;
            if (rem >= den) begin
              rem  = rem - den;
              f[0] = 1'b1;
            end
          end
          if (k >= 32) n_cutoff++;
          else n_graded++;
          ratio = exp_neg_q32(k, f);
        end
        thr = 64'(accept_r);
        thr = thr << (32 - RB);
        if (thr <= ratio) begin
          chain_q = 32'(cand);
          n_taken++;
        end else begin
          item.accepted = 1'b0;
          n_kept++;
        end
      end
      item.sample = chain_q;
      expected_samples.push_back(item);
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] sample, logic accepted);
      sample_item_t want;
      if (expected_samples.size() == 0) begin
        $error("unexpected result transaction: sample %h accepted %0b", sample, accepted);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      if (sample !== want.sample) begin
        $error("sample: expected %h, got %h", want.sample, sample);
        errors++;
      end
      if (accepted !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, accepted);
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          burst;
  bit          long_hold;
  int unsigned cycle_count;

  chain_checker board = new();

  gms_in_if #(.RANDOM_BITS(RB)) in_ch ();
  gms_out_if                    out_ch ();
  gms_cfg_if                    cfg_ch ();

  gaussian_metropolis_sampler #(
    .RANDOM_BITS(RB)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) board.check_sample(out_ch.sample, out_ch.accepted);
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
      end
      gap = burst ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    board.write_reg(idx, data);
  endtask

  task automatic set_target(logic [31:0] mean_v, logic [31:0] spread_v, bit poke_spare);
    cfg_write(REG_TARGET_MEAN, mean_v);
    cfg_write(REG_TARGET_SPREAD, spread_v);
    if (poke_spare) cfg_write(REG_SPARE, $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_item(bit restart, logic [RB-1:0] step_r, logic [RB-1:0] accept_r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.restart       <= restart;
    in_ch.step_random   <= step_r;
    in_ch.accept_random <= accept_r;
    do @(posedge clk_i); while (!in_ch.ready);
    board.predict_step(restart, step_r, accept_r);
  endtask

  // sender idles until every outstanding sample is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic random_target();
    logic [31:0] mean_v;
    logic [31:0] spread_v;
    case ($urandom_range(0, 3))
      0:       mean_v = $urandom;
      1:       mean_v = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      2:       mean_v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: mean_v = board.mean_q;
    endcase
    case ($urandom_range(0, 4))
      0:       spread_v = '0;
      1:       spread_v = $urandom_range(1, 1024);
      2:       spread_v = $urandom_range(32'h4000, 32'h4_0000);
      3:       spread_v = $urandom;
      default: spread_v = 32'h7FFF_FFFF;
    endcase
    spread_v[31] = 1'($urandom_range(0, 1));
    set_target(mean_v, spread_v, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst_ni              <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.restart       <= 1'b0;
    in_ch.step_random   <= '0;
    in_ch.accept_random <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_TARGET_MEAN;
    cfg_ch.data         <= '0;
    cycle_count         <= 0;
    burst     = 1'b0;
    long_hold = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: mean 0, spread 1.0
    send_item(1'b1, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 16'h8000, 16'hFFFF);
    send_item(1'b0, 16'h0000, 16'h0000);
    send_item(1'b0, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 16'hFFFF, 16'h0000);
    send_item(1'b0, 16'h0000, 16'hFFFF);
    send_item(1'b0, 16'h7FFF, 16'h8000);
    drain();
    // top of range, widest spread: candidate clips high
    set_target(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_item(1'b1, 16'h0000, 16'h0000);
    send_item(1'b0, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 16'h0000, 16'hFFFF);
    send_item(1'b0, 16'h0000, 16'h0000);
    send_item(1'b0, 16'hFFFF, 16'h0000);
    drain();
    // bottom of range, zero spread (top data bit ignored)
    set_target(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(1'b1, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 16'h0000, 16'hFFFF);
    send_item(1'b0, 16'hFFFF, 16'h0000);
    drain();
    // chain far below the mean: ratio underflows to zero
    set_target(32'h7FFF_FFFF, 32'h0000_0100, 1'b0);
    send_item(1'b0, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 16'h0000, 16'hFFFF);
    send_item(1'b0, 16'h0000, 16'h0000);
    drain();
    set_target(32'hFFEC_0000, 32'h8001_0000, 1'b0);
    send_item(1'b1, 16'h1234, 16'h5678);
    drain();
    // twenty sigma out: integer part of the exponent near ten
    set_target(32'h0000_0000, 32'h0001_0000, 1'b0);
    send_item(1'b0, 16'h0000, 16'hFFFF);
    send_item(1'b0, 16'h0000, 16'h0000);
    send_item(1'b0, 16'hFFFF, 16'hFFFF);

    for (int phase = 0; phase < 10; phase++) begin
      drain();
      random_target();
      burst = (phase % 4 == 1);
      if (phase == 2) long_hold = 1'b1;
      repeat (50) send_item($urandom_range(0, 15) == 0, RB'($urandom), RB'($urandom));
    end
    drain();
    repeat (20) @(posedge clk_i);

    $display("Ran %0d transactions: %0d restarts, %0d proposals taken, %0d kept.",
             board.n_items, board.n_restart, board.n_taken, board.n_kept);
    $display("Ratio paths: %0d flat, %0d graded, %0d cut off; %0d candidates clipped.",
             board.n_flat, board.n_graded, board.n_cutoff, board.n_clipped);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
